// ===== rtl/tdpt_pkg.sv =====
// Shared widths and sequencer state type for the trial-division prime test.
package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_W       = VALUE_WIDTH / 2 + 1;
  localparam int SQ_W        = VALUE_WIDTH + 1;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_DIV,
    ST_TEST,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// Negative, 0, 1 and even values skip the divisor loop and go straight to ST_FINISH.
// Odd values try each odd divisor 3, 5, ... up to sqrt(value) in ST_BOUND, ST_DIV and ST_TEST,
// stopping at the first that divides, using one radix-2 restoring remainder unit shared by all divisors.
// One item at a time; a new item is taken while the previous result waits at the output.
// rst is synchronous, active high; it clears the sequencer and the output valid.
module trial_division_prime_test (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   prime_flag
);
  import tdpt_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [VALUE_WIDTH-1:0]   v;
  logic [DIV_W-1:0]         d;
  logic [SQ_W-1:0]          sq;
  logic [DIV_W-1:0]         rem;
  logic [CNT_W-1:0]         cnt;
  logic                     res;

  logic                     in_fire;
  logic                     out_fire;
  logic                     quick_done;
  logic                     quick_res;
  logic                     over_bound;
  logic [DIV_W:0]           trial;
  logic [DIV_W:0]           trial_diff;
  logic [DIV_W-1:0]         rem_next;

  assign quick_done = candidate[VALUE_WIDTH-1] || !candidate[0] ||
                      (candidate == VALUE_WIDTH'(1));
  assign quick_res  = (candidate == VALUE_WIDTH'(2));
  assign over_bound = sq > {1'b0, v};

  // one restoring remainder step
  assign trial      = {rem, v[cnt]};
  assign trial_diff = trial - {1'b0, d};
  assign rem_next   = trial_diff[DIV_W] ? trial[DIV_W-1:0] : trial_diff[DIV_W-1:0];

  always_comb begin
    in_stall = rst || (state != ST_IDLE);
    in_fire  = in_valid && !in_stall;
    out_fire = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = quick_done ? ST_FINISH : ST_BOUND;
      ST_BOUND:  state_next = over_bound ? ST_FINISH : ST_DIV;
      ST_DIV:    if (cnt == '0) state_next = ST_TEST;
      ST_TEST:   state_next = (rem == '0) ? ST_FINISH : ST_BOUND;
      ST_FINISH: if (out_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) prime_flag <= res;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          v   <= candidate;
          d   <= DIV_W'(3);
          sq  <= SQ_W'(9);
          res <= quick_res;
        end
      end
      ST_BOUND: begin
        rem <= '0;
        cnt <= CNT_W'(VALUE_WIDTH - 1);
        if (over_bound) res <= 1'b1;
      end
      ST_DIV: begin
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
      end
      ST_TEST: begin
        if (rem == '0) res <= 1'b0;
        d  <= d + DIV_W'(2);
        sq <= sq + (SQ_W'(d) << 2) + SQ_W'(4);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tdpt_checker.sv =====
// Port-level checks for the trial-division prime test, bound to the top level.
module tdpt_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic signed [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic                                   prime_flag
);
  import tdpt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prime_flag))
    else $error("stalled result changed");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // no result appears in the cycle right after a transfer in
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // leaving busy always delivers a result
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) && !$past(rst) |-> out_valid)
    else $error("busy ended without result");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

// ===== bench/trial_division_prime_test_tb.sv =====
// Self-checking testbench for the trial-division prime test with randomized flow control.
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

  localparam int W = tdpt_pkg::VALUE_WIDTH;

  typedef struct {
    logic [W-1:0] cand;
    bit           flag;
  } verdict_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [W-1:0]   candidate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  prime_flag;

  logic [W-1:0]          candidates_pending[$];
  verdict_t              prime_verdicts[$];

  int unsigned           n_issued = 0;
  int unsigned           n_acc = 0;
  int unsigned           n_checked = 0;
  int unsigned           n_primes = 0;
  int unsigned           mismatches = 0;
  int unsigned           gap_left = 0;
  int unsigned           burst_left = 0;
  logic [15:0]           stall_phase = '0;
  stall_mode_t           stall_mode = STALL_NONE;

  trial_division_prime_test dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .candidate  (candidate),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prime_flag (prime_flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit trial_divide_prime(logic [W-1:0] value);
    longint unsigned n;
    longint unsigned d;
    n = value;
    if (value[W-1]) return 1'b0;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_flag(string what);
    $display("tb: mismatch: %s", what);
    mismatches++;
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_acc == n_issued) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (candidates_pending.size() > 0) begin
        candidate <= candidates_pending.pop_front();
        in_valid  <= 1'b1;
        n_issued++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, mode reselected whenever the low byte of stall_phase is zero.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase[7:0] == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 2));
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default:      out_stall <= (stall_phase[3:0] < 4'd11);
    endcase
  end

  // Monitor: predict on input transfer, check on output transfer.
  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        v.cand = candidate;
        v.flag = trial_divide_prime(candidate);
        prime_verdicts.push_back(v);
        n_acc++;
      end
      if (out_valid && !out_stall) begin
        if (prime_verdicts.size() == 0) begin
          report_flag($sformatf("unexpected result prime_flag=%0b", prime_flag));
        end else begin
          v = prime_verdicts.pop_front();
          n_checked++;
          if (v.flag) n_primes++;
          if (prime_flag !== v.flag)
            report_flag($sformatf("candidate %0d: prime_flag=%0b, want %0b",
                                  $signed(v.cand), prime_flag, v.flag));
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [W-1:0] val;

    // directed: extremes, small cases, squares, bound edge, largest prime
    candidates_pending.push_back(32'h8000_0000);
    candidates_pending.push_back(32'hFFFF_FFFF);
    candidates_pending.push_back(32'd0);
    candidates_pending.push_back(32'd1);
    candidates_pending.push_back(32'd2);
    candidates_pending.push_back(32'd3);
    candidates_pending.push_back(32'd4);
    candidates_pending.push_back(32'd5);
    candidates_pending.push_back(32'd9);
    candidates_pending.push_back(32'd15);
    candidates_pending.push_back(32'd25);
    candidates_pending.push_back(32'd49);
    candidates_pending.push_back(32'd97);
    candidates_pending.push_back(32'd127);
    candidates_pending.push_back(32'd63001);
    candidates_pending.push_back(32'd64507);
    candidates_pending.push_back(32'd65521);
    candidates_pending.push_back(32'd65535);
    candidates_pending.push_back(32'h5555_5555);
    candidates_pending.push_back(32'hAAAA_AAAA);
    candidates_pending.push_back(32'h7FFF_FFFE);
    candidates_pending.push_back(32'h7FFF_FFFD);
    candidates_pending.push_back(32'h7FFF_FFFF);

    // random: mostly small odd values, which exercise the divisor loop
    repeat (77) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      val = $urandom_range(1, 2047) * 2 + 1;
      else if (pick < 70) val = $urandom_range(1, 131071) * 2 + 1;
      else if (pick < 85) val = $urandom() & ~32'd1;
      else if (pick < 95) val = $urandom() | 32'h8000_0000;
      else begin
        val = $urandom_range(1, 180) * 2 + 1;
        val = val * val;
      end
      candidates_pending.push_back(val);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (candidates_pending.size() != 0 || n_acc != n_issued) @(negedge clk);
    while (prime_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("tb: %0d candidates checked, %0d prime, incl. extremes and 2^31-1",
             n_checked, n_primes);
    $display("tb: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: 2^31-1 is the slowest candidate; the run fails if the checks have not finished by the timeout.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
